/* rtl/swtp_pkg.sv */
// ---------------------------------------------------------------------------
// swtp_pkg
// Shared types, codes and the note step table of the square-wave tone player.
// ---------------------------------------------------------------------------
package swtp_pkg;

  localparam int unsigned CHANNELS_DEF = 3;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LVL_W  = 3;
  localparam int unsigned ACC_W  = 24;
  localparam int unsigned STEP_W = 22;
  localparam int unsigned WAIT_W = 16;

  localparam logic [ACC_W-1:0] ACC_RESTART = 24'd4194304;
  localparam logic [6:0]       TOP_NOTE    = 7'd123;

  // item commands
  localparam logic [CMD_W-1:0] CMD_POLL  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_MSEC  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_BYTE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_START = 3'd3;
  localparam logic [CMD_W-1:0] CMD_HALT  = 3'd4;

  // score opcodes (high nibble)
  localparam logic [3:0] OP_NOTE_OFF = 4'h8;
  localparam logic [3:0] OP_NOTE_ON  = 4'h9;
  localparam logic [3:0] OP_REWIND   = 4'hE;
  localparam logic [3:0] OP_END      = 4'hF;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_CMD    = 4'b0010,
    PH_NOTE   = 4'b0100,
    PH_WAITLO = 4'b1000
  } swtp_phase_t;

  // per-channel control from the interpreter
  typedef struct packed {
    logic              poll;
    logic              play;
    logic              silence;
    logic [STEP_W-1:0] step;
  } swtp_ch_ctl_t;

  typedef struct packed {
    logic score_active;
    logic want_byte;
    logic rewind;
  } swtp_status_t;

  function automatic logic [STEP_W-1:0] note_step(input logic [6:0] note);
    logic [STEP_W-1:0] s;
    case (note)
      7'd0: s = 22'd3429;       7'd1: s = 22'd3633;       7'd2: s = 22'd3849;
      7'd3: s = 22'd4078;       7'd4: s = 22'd4320;       7'd5: s = 22'd4577;
      7'd6: s = 22'd4850;       7'd7: s = 22'd5138;       7'd8: s = 22'd5443;
      7'd9: s = 22'd5767;       7'd10: s = 22'd6110;      7'd11: s = 22'd6473;
      7'd12: s = 22'd6858;      7'd13: s = 22'd7266;      7'd14: s = 22'd7698;
      7'd15: s = 22'd8156;      7'd16: s = 22'd8641;      7'd17: s = 22'd9155;
      7'd18: s = 22'd9699;      7'd19: s = 22'd10276;     7'd20: s = 22'd10887;
      7'd21: s = 22'd11534;     7'd22: s = 22'd12220;     7'd23: s = 22'd12947;
      7'd24: s = 22'd13717;     7'd25: s = 22'd14532;     7'd26: s = 22'd15396;
      7'd27: s = 22'd16312;     7'd28: s = 22'd17282;     7'd29: s = 22'd18310;
      7'd30: s = 22'd19398;     7'd31: s = 22'd20552;     7'd32: s = 22'd21774;
      7'd33: s = 22'd23069;     7'd34: s = 22'd24440;     7'd35: s = 22'd25894;
      7'd36: s = 22'd27433;     7'd37: s = 22'd29065;     7'd38: s = 22'd30793;
      7'd39: s = 22'd32624;     7'd40: s = 22'd34564;     7'd41: s = 22'd36619;
      7'd42: s = 22'd38797;     7'd43: s = 22'd41104;     7'd44: s = 22'd43548;
      7'd45: s = 22'd46137;     7'd46: s = 22'd48881;     7'd47: s = 22'd51787;
      7'd48: s = 22'd54867;     7'd49: s = 22'd58129;     7'd50: s = 22'd61586;
      7'd51: s = 22'd65248;     7'd52: s = 22'd69128;     7'd53: s = 22'd73238;
      7'd54: s = 22'd77593;     7'd55: s = 22'd82207;     7'd56: s = 22'd87096;
      7'd57: s = 22'd92275;     7'd58: s = 22'd97762;     7'd59: s = 22'd103575;
      7'd60: s = 22'd109734;    7'd61: s = 22'd116259;    7'd62: s = 22'd123172;
      7'd63: s = 22'd130496;    7'd64: s = 22'd138256;    7'd65: s = 22'd146477;
      7'd66: s = 22'd155187;    7'd67: s = 22'd164415;    7'd68: s = 22'd174191;
      7'd69: s = 22'd184549;    7'd70: s = 22'd195523;    7'd71: s = 22'd207150;
      7'd72: s = 22'd219467;    7'd73: s = 22'd232518;    7'd74: s = 22'd246344;
      7'd75: s = 22'd260992;    7'd76: s = 22'd276512;    7'd77: s = 22'd292954;
      7'd78: s = 22'd310374;    7'd79: s = 22'd328830;    7'd80: s = 22'd348383;
      7'd81: s = 22'd369099;    7'd82: s = 22'd391047;    7'd83: s = 22'd414299;
      7'd84: s = 22'd438935;    7'd85: s = 22'd465035;    7'd86: s = 22'd492688;
      7'd87: s = 22'd521984;    7'd88: s = 22'd553023;    7'd89: s = 22'd585908;
      7'd90: s = 22'd620748;    7'd91: s = 22'd657659;    7'd92: s = 22'd696766;
      7'd93: s = 22'd738198;    7'd94: s = 22'd782093;    7'd95: s = 22'd828599;
      7'd96: s = 22'd877870;    7'd97: s = 22'd930071;    7'd98: s = 22'd985375;
      7'd99: s = 22'd1043969;   7'd100: s = 22'd1106047;  7'd101: s = 22'd1171815;
      7'd102: s = 22'd1241495;  7'd103: s = 22'd1315318;  7'd104: s = 22'd1393531;
      7'd105: s = 22'd1476395;  7'd106: s = 22'd1564186;  7'd107: s = 22'd1657197;
      7'd108: s = 22'd1755739;  7'd109: s = 22'd1860141;  7'd110: s = 22'd1970751;
      7'd111: s = 22'd2087938;  7'd112: s = 22'd2212093;  7'd113: s = 22'd2343631;
      7'd114: s = 22'd2482991;  7'd115: s = 22'd2630637;  7'd116: s = 22'd2787063;
      7'd117: s = 22'd2952790;  7'd118: s = 22'd3128372;  7'd119: s = 22'd3314395;
      7'd120: s = 22'd3511479;  7'd121: s = 22'd3720282;  7'd122: s = 22'd3941502;
      default: s = 22'd4175876; // top note, and anything clamped to it
    endcase
    return s;
  endfunction

endpackage

/* rtl/swtp_in_if.sv */
// ---------------------------------------------------------------------------
// swtp_in_if
// Command item channel: tick, score byte and start/stop commands.
// ---------------------------------------------------------------------------
interface swtp_in_if;
  logic                          valid;
  logic                          ready;
  logic [swtp_pkg::CMD_W-1:0]    command;
  logic [swtp_pkg::BYTE_W-1:0]   score_byte;

  modport source (output valid, output command, output score_byte, input ready);
  modport sink   (input valid, input command, input score_byte, output ready);
endinterface

/* rtl/swtp_out_if.sv */
// ---------------------------------------------------------------------------
// swtp_out_if
// Result item channel: speaker levels and interpreter status.
// ---------------------------------------------------------------------------
interface swtp_out_if;
  logic                        valid;
  logic                        ready;
  logic [swtp_pkg::LVL_W-1:0]  speaker_levels;
  logic                        score_active;
  logic                        want_byte;
  logic                        rewind;

  modport source (output valid, output speaker_levels, output score_active,
                  output want_byte, output rewind, input ready);
  modport sink   (input valid, input speaker_levels, input score_active,
                  input want_byte, input rewind, output ready);
endinterface

/* rtl/score_driven_square_wave_tone_player.sv */
// ---------------------------------------------------------------------------
// score_driven_square_wave_tone_player
// Multi-voice square-wave score player with byte-wise score interpreter.
// ---------------------------------------------------------------------------
// Usage:
//   in_if carries one item per handshake: a command (poll tick, millisecond
//   tick, score byte, start or stop score) and the score byte. out_if returns
//   exactly one result item per input item: the speaker levels and the
//   interpreter status (score active, next byte wanted, rewind) as they stand
//   after that item.
//   An accepted item sits in the input register, is processed in one pass
//   into the result register and is offered from there. Throughput is one
//   item per cycle while out_if.ready stays high, set by the single-pass
//   update of the channel and interpreter state.
//   The input register is released as soon as the result register is free,
//   so a new item is taken while a finished result waits. If the receiver
//   holds out_if.ready low, the result is held and in_if.ready drops once
//   the input register is full; no item is lost.
//   Reset (rst_n low, synchronous) stops the score, silences all voices and
//   empties both registers.
// ---------------------------------------------------------------------------
module score_driven_square_wave_tone_player #(
  parameter int unsigned CHANNELS = swtp_pkg::CHANNELS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  swtp_in_if.sink    in_if,
  swtp_out_if.source out_if
);

  logic                          s1_valid_r;
  logic [swtp_pkg::CMD_W-1:0]    s1_cmd_r;
  logic [swtp_pkg::BYTE_W-1:0]   s1_byte_r;
  logic                          out_valid_r;
  logic [swtp_pkg::LVL_W-1:0]    out_levels_r;
  swtp_pkg::swtp_status_t        out_status_r;
  logic                          out_free, fire;
  swtp_pkg::swtp_ch_ctl_t        ctl [CHANNELS];
  swtp_pkg::swtp_status_t        status_nxt;
  logic [CHANNELS-1:0]           level_nxt;
  logic [swtp_pkg::LVL_W-1:0]    levels_nxt;

  assign out_free    = !out_valid_r || out_if.ready;
  assign fire        = s1_valid_r && out_free;
  assign in_if.ready = !s1_valid_r || out_free;

  swtp_interp #(.CHANNELS(CHANNELS)) u_interp (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .command    (s1_cmd_r),
    .score_byte (s1_byte_r),
    .ctl        (ctl),
    .status_nxt (status_nxt)
  );

  for (genvar i = 0; i < CHANNELS; i++) begin : g_ch
    swtp_channel u_ch (
      .clk       (clk),
      .rst_n     (rst_n),
      .fire      (fire),
      .ctl       (ctl[i]),
      .level_nxt (level_nxt[i])
    );
  end

  for (genvar b = 0; b < swtp_pkg::LVL_W; b++) begin : g_lvl
    if (b < CHANNELS) begin : g_on
      assign levels_nxt[b] = level_nxt[b];
    end else begin : g_off
      assign levels_nxt[b] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_if.ready) s1_valid_r <= in_if.valid;
      if (out_free)    out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_cmd_r  <= in_if.command;
      s1_byte_r <= in_if.score_byte;
    end
    if (fire) begin
      out_levels_r <= levels_nxt;
      out_status_r <= status_nxt;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.speaker_levels = out_levels_r;
  assign out_if.score_active   = out_status_r.score_active;
  assign out_if.want_byte      = out_status_r.want_byte;
  assign out_if.rewind         = out_status_r.rewind;

  // a byte is only asked for while the score runs
  a_want_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r.want_byte |-> out_status_r.score_active)
    else $error("byte wanted while score stopped");

  // rewind is only pending while a command byte is wanted
  a_rewind_needs_want: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r.rewind |-> out_status_r.want_byte)
    else $error("rewind pending with no byte wanted");

  // all voices are silent once the score has stopped
  a_quiet_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_status_r.score_active |-> out_levels_r == '0)
    else $error("speaker active while score stopped");

  // a held item stays in the input register while the result side stalls
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_free |=> s1_valid_r && $stable(s1_cmd_r))
    else $error("input register lost an item under stall");

endmodule

/* rtl/swtp_channel.sv */
// ---------------------------------------------------------------------------
// swtp_channel
// One square-wave voice: step accumulator and output level.
// ---------------------------------------------------------------------------
module swtp_channel (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  swtp_pkg::swtp_ch_ctl_t ctl,
  output logic                   level_nxt
);

  logic [swtp_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic [swtp_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                        on_r, on_nxt;
  logic                        level_r;
  logic [swtp_pkg::ACC_W:0]    diff;

  // borrow out of the subtract means the accumulator wrapped
  assign diff = {1'b0, acc_r} - {3'b000, step_r};

  always_comb begin
    acc_nxt   = acc_r;
    step_nxt  = step_r;
    on_nxt    = on_r;
    level_nxt = level_r;
    if (fire) begin
      if (ctl.silence) begin
        on_nxt    = 1'b0;
        level_nxt = 1'b0;
      end else if (ctl.play) begin
        step_nxt = ctl.step;
        acc_nxt  = swtp_pkg::ACC_RESTART;
        on_nxt   = 1'b1;
      end else if (ctl.poll && on_r) begin
        if (diff[swtp_pkg::ACC_W]) begin
          acc_nxt   = diff[swtp_pkg::ACC_W-1:0] + swtp_pkg::ACC_RESTART;
          level_nxt = !level_r;
        end else begin
          acc_nxt = diff[swtp_pkg::ACC_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_r    <= 1'b0;
      level_r <= 1'b0;
    end else begin
      on_r    <= on_nxt;
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    step_r <= step_nxt;
  end

endmodule

/* rtl/swtp_interp.sv */
// ---------------------------------------------------------------------------
// swtp_interp
// Score interpreter: byte parser, wait counter and per-channel control.
// ---------------------------------------------------------------------------
module swtp_interp #(
  parameter int unsigned CHANNELS = swtp_pkg::CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fire,
  input  logic [swtp_pkg::CMD_W-1:0]   command,
  input  logic [swtp_pkg::BYTE_W-1:0]  score_byte,
  output swtp_pkg::swtp_ch_ctl_t       ctl [CHANNELS],
  output swtp_pkg::swtp_status_t       status_nxt
);

  swtp_pkg::swtp_phase_t        phase_r, phase_nxt;
  logic [3:0]                   pend_ch_r, pend_ch_nxt;
  logic [6:0]                   wait_hi_r, wait_hi_nxt;
  logic [swtp_pkg::WAIT_W-1:0]  wait_r, wait_nxt;
  logic                         running_r, running_nxt;
  logic                         rewind_r, rewind_nxt;
  logic                         poll, play, silence_one, silence_all;
  logic [6:0]                   note;
  logic [swtp_pkg::STEP_W-1:0]  note_step;

  assign note = (score_byte > {1'b0, swtp_pkg::TOP_NOTE}) ? swtp_pkg::TOP_NOTE
                                                          : score_byte[6:0];
  assign note_step = swtp_pkg::note_step(note);

  always_comb begin
    phase_nxt   = phase_r;
    pend_ch_nxt = pend_ch_r;
    wait_hi_nxt = wait_hi_r;
    wait_nxt    = wait_r;
    running_nxt = running_r;
    rewind_nxt  = rewind_r;
    poll        = 1'b0;
    play        = 1'b0;
    silence_one = 1'b0;
    silence_all = 1'b0;
    if (fire) begin
      case (command)
        swtp_pkg::CMD_POLL: begin
          poll = 1'b1;
        end
        swtp_pkg::CMD_MSEC: begin
          if (running_r && wait_r != '0) begin
            wait_nxt = wait_r - 1'b1;
            if (wait_r == swtp_pkg::WAIT_W'(1)) phase_nxt = swtp_pkg::PH_CMD;
          end
        end
        swtp_pkg::CMD_BYTE: begin
          if (phase_r != swtp_pkg::PH_IDLE) rewind_nxt = 1'b0;
          case (phase_r)
            swtp_pkg::PH_NOTE: begin
              play      = 1'b1;
              phase_nxt = swtp_pkg::PH_CMD;
            end
            swtp_pkg::PH_WAITLO: begin
              wait_nxt  = {1'b0, wait_hi_r, score_byte} + 1'b1;
              phase_nxt = swtp_pkg::PH_IDLE;
            end
            swtp_pkg::PH_CMD: begin
              if (!score_byte[7]) begin
                wait_hi_nxt = score_byte[6:0];
                phase_nxt   = swtp_pkg::PH_WAITLO;
              end else begin
                case (score_byte[7:4])
                  swtp_pkg::OP_NOTE_OFF: silence_one = 1'b1;
                  swtp_pkg::OP_NOTE_ON: begin
                    pend_ch_nxt = score_byte[3:0];
                    phase_nxt   = swtp_pkg::PH_NOTE;
                  end
                  swtp_pkg::OP_REWIND: rewind_nxt = 1'b1;
                  swtp_pkg::OP_END: begin
                    silence_all = 1'b1;
                    running_nxt = 1'b0;
                    phase_nxt   = swtp_pkg::PH_IDLE;
                    wait_nxt    = '0;
                    rewind_nxt  = 1'b0;
                  end
                  default: ;
                endcase
              end
            end
            default: ;
          endcase
        end
        swtp_pkg::CMD_START: begin
          silence_all = 1'b1;
          running_nxt = 1'b1;
          phase_nxt   = swtp_pkg::PH_CMD;
          wait_nxt    = '0;
          rewind_nxt  = 1'b1;
        end
        swtp_pkg::CMD_HALT: begin
          silence_all = 1'b1;
          running_nxt = 1'b0;
          phase_nxt   = swtp_pkg::PH_IDLE;
          wait_nxt    = '0;
          rewind_nxt  = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // a channel number beyond the last voice matches no channel
  for (genvar i = 0; i < CHANNELS; i++) begin : g_ctl
    assign ctl[i].poll    = poll;
    assign ctl[i].play    = play && (pend_ch_r == 4'(i));
    assign ctl[i].silence = silence_all || (silence_one && score_byte[3:0] == 4'(i));
    assign ctl[i].step    = note_step;
  end

  assign status_nxt.score_active = running_nxt;
  assign status_nxt.want_byte    = (phase_nxt != swtp_pkg::PH_IDLE);
  assign status_nxt.rewind       = rewind_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= swtp_pkg::PH_IDLE;
      pend_ch_r <= '0;
      wait_hi_r <= '0;
      wait_r    <= '0;
      running_r <= 1'b0;
      rewind_r  <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      pend_ch_r <= pend_ch_nxt;
      wait_hi_r <= wait_hi_nxt;
      wait_r    <= wait_nxt;
      running_r <= running_nxt;
      rewind_r  <= rewind_nxt;
    end
  end

endmodule
